@@ src/ftps_pkg.sv @@
// shared types and constants for the fat-tree path selector
`timescale 1ns / 1ps
`default_nettype none

package ftps_pkg;

  // limits of the routing core
  localparam int POD_LIMIT      = 16;
  localparam int CORE_LIMIT     = 64;
  localparam int SERVER_ID_BITS = 12;

  // field and operand widths
  localparam int ID_W   = 12;   // server number width on the stream
  localparam int CFG_W  = 7;    // widest configuration register
  localparam int PCNT_W = 5;    // pods-in-use register
  localparam int SEL_W  = 6;    // rack, server, agg and core indexes
  localparam int POD_W  = 4;
  localparam int HOP_W  = 3;    // hop index and hop count
  localparam int CIDX_W = 3;    // configuration register index

  localparam int ID_KEEP = (SERVER_ID_BITS < ID_W) ? SERVER_ID_BITS : ID_W;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << ID_KEEP) - 1);

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SPR   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_RPP   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_AGGS  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_PODS  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_CORES = 3'd4;

  typedef enum logic [1:0] {
    HOP_SRV_TOR  = 2'd0,
    HOP_TOR_AGG  = 2'd1,
    HOP_POD_CORE = 2'd2
  } hop_kind_e;

  // what the shared divider lanes are working on
  typedef enum logic [1:0] {
    DIV_SRV   = 2'd0,   // server number / servers_per_rack
    DIV_RACK  = 2'd1,   // rack quotient / racks_per_pod
    DIV_SHARE = 2'd2,   // cores / aggs
    DIV_AGG   = 2'd3    // core / cores per agg
  } div_op_e;

  typedef struct packed {
    logic                 start;
    div_op_e              start_op;
    logic                 cap;
    div_op_e              cap_op;
    logic                 take_agg;
    logic                 take_core;
    logic                 emit;
    logic [HOP_W-1:0]     hops;
    logic [HOP_W-1:0]     hop_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic srv_match;
    logic rack_match;
    logic pod_match;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/ftps_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module ftps_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ftps_pkg::ID_W-1:0]    dividend_i,
  input  wire logic [ftps_pkg::CFG_W-1:0]   divisor_i,
  output logic      [ftps_pkg::ID_W-1:0]    quot_o,
  output logic      [ftps_pkg::SEL_W-1:0]   rem_o,
  output logic                              done_o
);

  localparam int CNT_W = $clog2(ftps_pkg::ID_W);

  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ftps_pkg::ID_W-1:0]     dq_q, dq_d;
  logic [ftps_pkg::SEL_W-1:0]    rem_q, rem_d;
  logic [ftps_pkg::CFG_W-1:0]    dvs_q, dvs_d;
  logic [ftps_pkg::CFG_W-1:0]    trial;
  logic [ftps_pkg::CFG_W-1:0]    diff;
  logic                          fits;

  // remainder stays below the divisor (at most 64), so the shifted value fits 7 bits
  assign trial = {rem_q, dq_q[ftps_pkg::ID_W-1]};
  assign fits  = (trial >= dvs_q);
  assign diff  = trial - dvs_q;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[ftps_pkg::ID_W-2:0], fits};
      rem_d = fits ? diff[ftps_pkg::SEL_W-1:0] : trial[ftps_pkg::SEL_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ftps_pkg::ID_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_o = dq_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ src/ftps_ctrl.sv @@
// sequencing state machine for the path selector
`timescale 1ns / 1ps
`default_nettype none

module ftps_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ftps_pkg::dp_status_t status_i,
  output ftps_pkg::dp_cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRV    = 3'd1;
  localparam logic [2:0] S_RACK   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHARE  = 3'd4;
  localparam logic [2:0] S_AGGDIV = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]                    state_q, state_d;
  logic [ftps_pkg::HOP_W-1:0]    hop_q, hop_d;
  logic [ftps_pkg::HOP_W-1:0]    hops_q, hops_d;

  always_comb begin
    state_d       = state_q;
    hop_d         = hop_q;
    hops_d        = hops_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.hops    = hops_q;
    cmd_o.hop_idx = hop_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start    = 1'b1;
          cmd_o.start_op = ftps_pkg::DIV_SRV;
          state_d        = S_SRV;
        end
      end
      S_SRV: begin
        if (status_i.div_done) begin
          cmd_o.cap      = 1'b1;
          cmd_o.cap_op   = ftps_pkg::DIV_SRV;
          cmd_o.start    = 1'b1;
          cmd_o.start_op = ftps_pkg::DIV_RACK;
          state_d        = S_RACK;
        end
      end
      S_RACK: begin
        if (status_i.div_done) begin
          cmd_o.cap    = 1'b1;
          cmd_o.cap_op = ftps_pkg::DIV_RACK;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        hop_d = '0;
        priority if (status_i.srv_match) begin
          state_d = S_IDLE;
        end else if (status_i.rack_match) begin
          hops_d  = 3'd2;
          state_d = S_EMIT;
        end else if (status_i.pod_match) begin
          cmd_o.take_agg = 1'b1;
          hops_d         = 3'd4;
          state_d        = S_EMIT;
        end else begin
          cmd_o.take_core = 1'b1;
          cmd_o.start     = 1'b1;
          cmd_o.start_op  = ftps_pkg::DIV_SHARE;
          hops_d          = 3'd6;
          state_d         = S_SHARE;
        end
      end
      S_SHARE: begin
        if (status_i.div_done) begin
          cmd_o.start    = 1'b1;
          cmd_o.start_op = ftps_pkg::DIV_AGG;
          state_d        = S_AGGDIV;
        end
      end
      S_AGGDIV: begin
        if (status_i.div_done) begin
          cmd_o.cap    = 1'b1;
          cmd_o.cap_op = ftps_pkg::DIV_AGG;
          state_d      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (hop_q == hops_q - 3'd1) begin
            state_d = S_IDLE;
          end else begin
            hop_d = hop_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hop_q   <= '0;
      hops_q  <= '0;
    end else begin
      state_q <= state_d;
      hop_q   <= hop_d;
      hops_q  <= hops_d;
    end
  end

endmodule

`default_nettype wire

@@ src/ftps_dp.sv @@
// datapath: configuration, divider lanes, locations, pointers and result register
`timescale 1ns / 1ps
`default_nettype none

module ftps_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ftps_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [ftps_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic [2*ftps_pkg::ID_W-1:0]   in_data_i,
  input  wire ftps_pkg::dp_cmd_t             cmd_i,
  output ftps_pkg::dp_status_t               status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [15:0]                        out_data_o,
  output logic [2:0]                         out_user_o,
  output logic                               out_last_o
);

  localparam int PTR_N = 1 << ftps_pkg::POD_W;

  logic [ftps_pkg::CFG_W-1:0]  spr_q, rpp_q, aggs_q, cores_q;
  logic [ftps_pkg::PCNT_W-1:0] pods_q;

  logic [ftps_pkg::CFG_W-1:0]  spr, rpp, aggs, cores;
  logic [ftps_pkg::PCNT_W-1:0] pods;

  function automatic logic [ftps_pkg::CFG_W-1:0] clamp7(
    input logic [ftps_pkg::CFG_W-1:0] v,
    input logic [ftps_pkg::CFG_W-1:0] hi
  );
    logic [ftps_pkg::CFG_W-1:0] r;
    if (v == '0) r = 7'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // effective sizes
  always_comb begin
    spr   = clamp7(spr_q, 7'd64);
    rpp   = clamp7(rpp_q, 7'd64);
    aggs  = clamp7(aggs_q, 7'd64);
    cores = clamp7(cores_q, 7'd64);
    if (32'(cores) > ftps_pkg::CORE_LIMIT) cores = ftps_pkg::CFG_W'(ftps_pkg::CORE_LIMIT);
    if (pods_q == '0) pods = 5'd1;
    else if (pods_q > 5'd16) pods = 5'd16;
    else pods = pods_q;
    if (32'(pods) > ftps_pkg::POD_LIMIT) pods = ftps_pkg::PCNT_W'(ftps_pkg::POD_LIMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q   <= 7'd4;
      rpp_q   <= 7'd4;
      aggs_q  <= 7'd2;
      pods_q  <= 5'd4;
      cores_q <= 7'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ftps_pkg::CFG_SPR:   spr_q   <= cfg_data_i;
        ftps_pkg::CFG_RPP:   rpp_q   <= cfg_data_i;
        ftps_pkg::CFG_AGGS:  aggs_q  <= cfg_data_i;
        ftps_pkg::CFG_PODS:  pods_q  <= cfg_data_i[ftps_pkg::PCNT_W-1:0];
        ftps_pkg::CFG_CORES: cores_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divider lanes: lane 0 source side, lane 1 destination side
  logic [ftps_pkg::ID_W-1:0]  a0, a1, q0, q1;
  logic [ftps_pkg::CFG_W-1:0] dvs, per_agg;
  logic [ftps_pkg::SEL_W-1:0] r0, r1;
  logic                       done0, done1;
  logic [ftps_pkg::SEL_W-1:0] core_q;

  assign per_agg = (q0 == '0) ? 7'd1 : q0[ftps_pkg::CFG_W-1:0];

  always_comb begin
    unique case (cmd_i.start_op)
      ftps_pkg::DIV_SRV: begin
        a0  = in_data_i[ftps_pkg::ID_W-1:0] & ftps_pkg::ID_MASK;
        a1  = in_data_i[2*ftps_pkg::ID_W-1:ftps_pkg::ID_W] & ftps_pkg::ID_MASK;
        dvs = spr;
      end
      ftps_pkg::DIV_RACK: begin
        a0  = q0;
        a1  = q1;
        dvs = rpp;
      end
      ftps_pkg::DIV_SHARE: begin
        a0  = ftps_pkg::ID_W'(cores);
        a1  = ftps_pkg::ID_W'(cores);
        dvs = aggs;
      end
      ftps_pkg::DIV_AGG: begin
        a0  = ftps_pkg::ID_W'(core_q);
        a1  = ftps_pkg::ID_W'(core_q);
        dvs = per_agg;
      end
      default: begin
        a0  = '0;
        a1  = '0;
        dvs = 7'd1;
      end
    endcase
  end

  ftps_div u_div_src (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (a0),
    .divisor_i  (dvs),
    .quot_o     (q0),
    .rem_o      (r0),
    .done_o     (done0)
  );

  ftps_div u_div_dst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (a1),
    .divisor_i  (dvs),
    .quot_o     (q1),
    .rem_o      (r1),
    .done_o     (done1)
  );

  // flow endpoints
  logic [ftps_pkg::SEL_W-1:0] srv_s_q, srv_d_q, rack_s_q, rack_d_q, agg_q;
  logic [ftps_pkg::POD_W-1:0] pod_s_q, pod_d_q;
  logic [ftps_pkg::POD_W-1:0] pod_s, pod_d, pod_top;

  assign pod_top = ftps_pkg::POD_W'(pods - 5'd1);
  assign pod_s   = (q0 >= ftps_pkg::ID_W'(pods)) ? pod_top : q0[ftps_pkg::POD_W-1:0];
  assign pod_d   = (q1 >= ftps_pkg::ID_W'(pods)) ? pod_top : q1[ftps_pkg::POD_W-1:0];

  // round-robin pointers
  logic [ftps_pkg::SEL_W-1:0] agg_ptr_q [PTR_N];
  logic [ftps_pkg::SEL_W-1:0] core_ptr_q;
  logic [ftps_pkg::SEL_W-1:0] agg_cur, agg_pick, agg_nxt, core_pick, core_nxt;
  logic [ftps_pkg::CFG_W-1:0] agg_inc, core_inc;
  logic [ftps_pkg::SEL_W-1:0] agg_sat;

  always_comb begin
    agg_cur   = agg_ptr_q[pod_s_q];
    agg_pick  = ({1'b0, agg_cur} >= aggs) ? '0 : agg_cur;
    agg_inc   = {1'b0, agg_pick} + 7'd1;
    agg_nxt   = (agg_inc >= aggs) ? '0 : agg_inc[ftps_pkg::SEL_W-1:0];
    core_pick = ({1'b0, core_ptr_q} >= cores) ? '0 : core_ptr_q;
    core_inc  = {1'b0, core_pick} + 7'd1;
    core_nxt  = (core_inc >= cores) ? '0 : core_inc[ftps_pkg::SEL_W-1:0];
    agg_sat   = (q0 >= ftps_pkg::ID_W'(aggs)) ? ftps_pkg::SEL_W'(aggs - 7'd1)
                                              : q0[ftps_pkg::SEL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PTR_N; k++) agg_ptr_q[k] <= '0;
      core_ptr_q <= '0;
    end else begin
      if (cmd_i.take_agg) agg_ptr_q[pod_s_q] <= agg_nxt;
      if (cmd_i.take_core) core_ptr_q <= core_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      unique case (cmd_i.cap_op)
        ftps_pkg::DIV_SRV: begin
          srv_s_q <= r0;
          srv_d_q <= r1;
        end
        ftps_pkg::DIV_RACK: begin
          rack_s_q <= r0;
          rack_d_q <= r1;
          pod_s_q  <= pod_s;
          pod_d_q  <= pod_d;
        end
        ftps_pkg::DIV_AGG: agg_q <= agg_sat;
        default: ;
      endcase
    end
    if (cmd_i.take_agg) agg_q <= agg_pick;
    if (cmd_i.take_core) core_q <= core_pick;
  end

  // hop i of n: first half climbs from the source, second half descends to the destination
  logic [ftps_pkg::HOP_W-1:0] mirror, layer3;
  logic                       down, last;
  ftps_pkg::hop_kind_e        kind;
  logic [ftps_pkg::POD_W-1:0] h_pod;
  logic [ftps_pkg::SEL_W-1:0] h_rack, h_port;

  always_comb begin
    down   = (cmd_i.hop_idx >= (cmd_i.hops >> 1));
    mirror = cmd_i.hops - 3'd1 - cmd_i.hop_idx;
    layer3 = down ? mirror : cmd_i.hop_idx;
    kind   = ftps_pkg::hop_kind_e'(layer3[1:0]);
    last   = (mirror == '0);
    h_pod  = down ? pod_d_q : pod_s_q;
    unique case (kind)
      ftps_pkg::HOP_SRV_TOR: begin
        h_rack = down ? rack_d_q : rack_s_q;
        h_port = down ? srv_d_q : srv_s_q;
      end
      ftps_pkg::HOP_TOR_AGG: begin
        h_rack = down ? rack_d_q : rack_s_q;
        h_port = agg_q;
      end
      ftps_pkg::HOP_POD_CORE: begin
        h_rack = '0;
        h_port = core_q;
      end
      default: begin
        h_rack = '0;
        h_port = '0;
      end
    endcase
  end

  // result register
  logic        ovalid_q;
  logic [15:0] odata_q;
  logic [2:0]  ouser_q;
  logic        olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      odata_q <= {h_port, h_rack, h_pod};
      ouser_q <= {down, kind};
      olast_q <= last;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_user_o  = ouser_q;
  assign out_last_o  = olast_q;

  assign status_o.div_done   = done0 & done1;
  assign status_o.pod_match  = (pod_s_q == pod_d_q);
  assign status_o.rack_match = status_o.pod_match && (rack_s_q == rack_d_q);
  assign status_o.srv_match  = status_o.rack_match && (srv_s_q == srv_d_q);
  assign status_o.out_free   = !ovalid_q || out_ready_i;

endmodule

`default_nettype wire

@@ src/fat_tree_path_selector.sv @@
// top level: round-robin path selection over a three-layer fat tree
// path shape: same rack or pod takes two divider passes plus a decision state before
//   the first hop, other pods four passes
// throughput: one flow at a time, then one hop per cycle from the result register while
//   m_axis_tready is high; the divider lanes (one quotient bit per cycle) set the pace
// reset: async active low; sizes return to 4/4/2/4/4 and all round-robin pointers to zero
`timescale 1ns / 1ps
`default_nettype none

module fat_tree_path_selector (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [ftps_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  wire logic [ftps_pkg::CFG_W-1:0]   cfg_data_i,
  // flow requests
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,   // src_server, dst_server
  // hop results
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // hop_pod, hop_rack, hop_port
  output logic [2:0]                        m_axis_tuser,   // hop_kind, going_down
  output logic                              m_axis_tlast    // last_hop
);

  // command and status between sequencer and datapath
  ftps_pkg::dp_cmd_t    cmd;
  ftps_pkg::dp_status_t status;

  // sequencer: runs the divider passes, picks the path shape, steps the hops
  ftps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: size registers, two divider lanes, pointers, hop register
  ftps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // a hop is only loaded when the result register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("hop loaded over a pending result");

  // the final hop always lands on the destination server link
  a_last_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser[2] && (m_axis_tuser[1:0] == ftps_pkg::HOP_SRV_TOR)))
    else $error("last hop is not a downward server link");

  // one flow at a time: no new request right after an accepted one
  a_one_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second flow accepted while busy");

  // core pointer advances only for flows that leave the pod
  a_core_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take_core |-> !status.pod_match)
    else $error("core picked for an intra-pod flow");
`endif

endmodule

`default_nettype wire

@@ verif/ftps_route_checker.sv @@
`timescale 1ns / 1ps
// scoreboard for the fat-tree path selector: predicts the hops of each flow and compares them

module ftps_route_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ftps_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  wire logic [ftps_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                         flow_valid_i,
  input  wire logic                         flow_ready_i,
  input  wire logic [23:0]                  flow_data_i,   // src_server, dst_server
  input  wire logic                         hop_valid_i,
  input  wire logic                         hop_ready_i,
  input  wire logic [15:0]                  hop_data_i,    // hop_pod, hop_rack, hop_port
  input  wire logic [2:0]                   hop_user_i,    // hop_kind, going_down
  input  wire logic                         hop_last_i,
  output int                                mismatch_count_o,
  output int                                hops_owed_o
);

  localparam logic LINK_UP   = 1'b0;
  localparam logic LINK_DOWN = 1'b1;

  typedef struct packed {
    ftps_pkg::hop_kind_e kind;
    logic                down;
    logic [3:0]          pod;
    logic [5:0]          rack;
    logic [5:0]          port;
    logic                last;
  } hop_t;

  typedef struct packed {
    logic [11:0] pod;
    logic [11:0] rack;
    logic [11:0] srv;
  } site_t;

  // shadow copy of the sizes and the round-robin pointers
  logic [6:0] spr_r, rpp_r, aggs_r, cores_r;
  logic [4:0] pods_r;
  logic [5:0] agg_ptr [16];
  logic [5:0] core_ptr;
  hop_t       hops_owed_q [$];
  int         mismatches;

  function automatic int fit(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic site_t locate_server(logic [11:0] id);
    int    spr, rpp, pods, idn, q, pod;
    site_t s;
    spr  = fit(spr_r, 64);
    rpp  = fit(rpp_r, 64);
    pods = fit(pods_r, 16);
    if (pods > ftps_pkg::POD_LIMIT) pods = ftps_pkg::POD_LIMIT;
    idn  = int'(id) & ((1 << ftps_pkg::SERVER_ID_BITS) - 1);
    q    = idn / spr;
    pod  = q / rpp;
    // pods past the configured count fold into the last one
    if (pod >= pods) pod = pods - 1;
    s.srv  = 12'(idn % spr);
    s.rack = 12'(q % rpp);
    s.pod  = 12'(pod);
    return s;
  endfunction

  function automatic void owe_hop(ftps_pkg::hop_kind_e kind, logic down, int pod, int rack,
                                  int port, logic last);
    hop_t h;
    h.kind = kind;
    h.down = down;
    h.pod  = 4'(pod);
    h.rack = 6'(rack);
    h.port = 6'(port);
    h.last = last;
    hops_owed_q.insert(hops_owed_q.size(), h);
  endfunction

  function automatic void plan_route(logic [11:0] src_id, logic [11:0] dst_id);
    site_t s, d;
    int    aggs, cores, agg, core, per_agg, p;
    s    = locate_server(src_id);
    d    = locate_server(dst_id);
    aggs = fit(aggs_r, 64);
    if (s == d) return;
    if (s.pod == d.pod && s.rack == d.rack) begin
      owe_hop(ftps_pkg::HOP_SRV_TOR, LINK_UP,   s.pod, s.rack, s.srv, 1'b0);
      owe_hop(ftps_pkg::HOP_SRV_TOR, LINK_DOWN, d.pod, d.rack, d.srv, 1'b1);
    end else if (s.pod == d.pod) begin
      p   = int'(s.pod) & 15;
      agg = agg_ptr[p];
      // a pointer left over from a larger setting restarts at zero
      if (agg >= aggs) agg = 0;
      agg_ptr[p] = (agg + 1 >= aggs) ? 6'd0 : 6'(agg + 1);
      owe_hop(ftps_pkg::HOP_SRV_TOR, LINK_UP,   s.pod, s.rack, s.srv, 1'b0);
      owe_hop(ftps_pkg::HOP_TOR_AGG, LINK_UP,   s.pod, s.rack, agg,   1'b0);
      owe_hop(ftps_pkg::HOP_TOR_AGG, LINK_DOWN, d.pod, d.rack, agg,   1'b0);
      owe_hop(ftps_pkg::HOP_SRV_TOR, LINK_DOWN, d.pod, d.rack, d.srv, 1'b1);
    end else begin
      cores = fit(cores_r, 64);
      if (cores > ftps_pkg::CORE_LIMIT) cores = ftps_pkg::CORE_LIMIT;
      core = core_ptr;
      if (core >= cores) core = 0;
      core_ptr = (core + 1 >= cores) ? 6'd0 : 6'(core + 1);
      per_agg = cores / aggs;
      if (per_agg == 0) per_agg = 1;
      agg = core / per_agg;
      if (agg >= aggs) agg = aggs - 1;
      owe_hop(ftps_pkg::HOP_SRV_TOR,  LINK_UP,   s.pod, s.rack, s.srv, 1'b0);
      owe_hop(ftps_pkg::HOP_TOR_AGG,  LINK_UP,   s.pod, s.rack, agg,   1'b0);
      owe_hop(ftps_pkg::HOP_POD_CORE, LINK_UP,   s.pod, 0,      core,  1'b0);
      owe_hop(ftps_pkg::HOP_POD_CORE, LINK_DOWN, d.pod, 0,      core,  1'b0);
      owe_hop(ftps_pkg::HOP_TOR_AGG,  LINK_DOWN, d.pod, d.rack, agg,   1'b0);
      owe_hop(ftps_pkg::HOP_SRV_TOR,  LINK_DOWN, d.pod, d.rack, d.srv, 1'b1);
    end
  endfunction

  function automatic string show_hop(hop_t h);
    return $sformatf("kind=%0d down=%0d pod=%0d rack=%0d port=%0d last=%0d",
                     h.kind, h.down, h.pod, h.rack, h.port, h.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    hop_t seen, want;
    if (!rst_ni) begin
      spr_r   = 7'd4;
      rpp_r   = 7'd4;
      aggs_r  = 7'd2;
      pods_r  = 5'd4;
      cores_r = 7'd4;
      for (int i = 0; i < 16; i++) agg_ptr[i] = '0;
      core_ptr = '0;
      hops_owed_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ftps_pkg::CFG_SPR:   spr_r   = cfg_data_i;
          ftps_pkg::CFG_RPP:   rpp_r   = cfg_data_i;
          ftps_pkg::CFG_AGGS:  aggs_r  = cfg_data_i;
          ftps_pkg::CFG_PODS:  pods_r  = cfg_data_i[4:0];
          ftps_pkg::CFG_CORES: cores_r = cfg_data_i;
          default: ;
        endcase
      end
      if (hop_valid_i && hop_ready_i) begin
        seen.kind = ftps_pkg::hop_kind_e'(hop_user_i[1:0]);
        seen.down = hop_user_i[2];
        seen.pod  = hop_data_i[3:0];
        seen.rack = hop_data_i[9:4];
        seen.port = hop_data_i[15:10];
        seen.last = hop_last_i;
        if (hops_owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected hop: %s", show_hop(seen));
        end else begin
          want = hops_owed_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hop mismatch: expected %s, got %s", show_hop(want), show_hop(seen));
          end
        end
      end
      if (flow_valid_i && flow_ready_i) plan_route(flow_data_i[11:0], flow_data_i[23:12]);
    end
    mismatch_count_o <= mismatches;
    hops_owed_o      <= hops_owed_q.size();
  end

endmodule

@@ verif/fat_tree_path_selector_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the fat-tree path selector: stimulus, flow control and verdict

module fat_tree_path_selector_tb;

  localparam int HALF_PERIOD = 4;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int SETTLE      = 80;    // covers a same-server flow still in the dividers
  localparam int LONG_HOLD   = 300;   // one long receiver stall
  localparam int PHASES      = 10;
  localparam int PHASE_FLOWS = 30;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ftps_pkg::CIDX_W-1:0]   cfg_idx_i;
  logic [ftps_pkg::CFG_W-1:0]    cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata;   // src_server, dst_server
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [15:0]                   m_axis_tdata;   // hop_pod, hop_rack, hop_port
  logic [2:0]                    m_axis_tuser;   // hop_kind, going_down
  logic                          m_axis_tlast;   // last_hop

  int   mismatches;
  int   hops_owed;
  int   idle_cycles;
  int   burst_left;
  logic long_hold_req;

  // sizes as the block sees them, used only to aim the random flows
  int   eff_spr, eff_rpp, eff_pods;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  fat_tree_path_selector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ftps_route_checker u_route_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .flow_valid_i     (s_axis_tvalid),
    .flow_ready_i     (s_axis_tready),
    .flow_data_i      (s_axis_tdata),
    .hop_valid_i      (m_axis_tvalid),
    .hop_ready_i      (m_axis_tready),
    .hop_data_i       (m_axis_tdata),
    .hop_user_i       (m_axis_tuser),
    .hop_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .hops_owed_o      (hops_owed)
  );

  function automatic int fit(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // server number from pod, rack and server; ids past the 12-bit space fall back to noise
  function automatic logic [11:0] place_server(int pod, int rack, int srv);
    int id;
    id = (pod * eff_rpp + rack) * eff_spr + srv;
    if (id > 4095) return 12'($urandom_range(0, 4095));
    return 12'(id);
  endfunction

  // sizes per phase, packed as {cores, pods, aggs, racks, servers}
  function automatic logic [34:0] phase_sizes(int n);
    case (n)
      0:       return {7'd1,   7'd16, 7'd1,  7'd1,  7'd1};    // smallest fabric, many pods
      1:       return {7'd64,  7'd16, 7'd64, 7'd64, 7'd64};   // largest sizes
      2:       return {7'd127, 7'd31, 7'd5,  7'd0,  7'd127};  // zero and over-range values
      3:       return {7'd0,   7'd3,  7'd0,  7'd5,  7'd0};    // pointers go stale here
      4:       return {7'd4,   7'd5,  7'd6,  7'd2,  7'd3};    // fewer cores than aggs
      5:       return {7'd7,   7'd6,  7'd3,  7'd3,  7'd5};    // core-to-agg saturation
      6:       return {7'd12,  7'd7,  7'd4,  7'd3,  7'd4};
      7:       return {7'd64,  7'd16, 7'd3,  7'd9,  7'd7};
      8:       return {7'd7,   7'd1,  7'd64, 7'd2,  7'd2};    // single pod
      default: return {7'd4,   7'd4,  7'd2,  7'd4,  7'd4};    // back to reset sizes
    endcase
  endfunction

  task automatic pause_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // offer one flow; bursts of random length are separated by random gaps
  task automatic send_flow(logic [11:0] src_id, logic [11:0] dst_id);
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dst_id, src_id};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender until every hop is out and the block has gone quiet
  task automatic drain_flows();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (hops_owed != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [ftps_pkg::CIDX_W-1:0] idx, logic [6:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_sizes(logic [34:0] sz);
    drain_flows();
    write_reg(ftps_pkg::CFG_SPR,   sz[6:0]);
    write_reg(ftps_pkg::CFG_RPP,   sz[13:7]);
    write_reg(ftps_pkg::CFG_AGGS,  sz[20:14]);
    write_reg(ftps_pkg::CFG_PODS,  sz[27:21]);
    write_reg(ftps_pkg::CFG_CORES, sz[34:28]);
    cfg_we_i <= 1'b0;
    eff_spr  = fit(sz[6:0], 64);
    eff_rpp  = fit(sz[13:7], 64);
    eff_pods = fit(sz[25:21], 16);
  endtask

  // random flow aimed at one of the route classes, with some pure noise
  task automatic send_random_flow();
    int          pick, pod, rack;
    logic [11:0] src_id, dst_id;
    pick   = $urandom_range(0, 99);
    pod    = $urandom_range(0, eff_pods);        // one past the count now and then
    rack   = $urandom_range(0, eff_rpp - 1);
    src_id = place_server(pod, rack, $urandom_range(0, eff_spr - 1));
    if (pick < 8) begin
      dst_id = src_id;
    end else if (pick < 30) begin
      dst_id = place_server(pod, rack, $urandom_range(0, eff_spr - 1));
    end else if (pick < 55) begin
      dst_id = place_server(pod, $urandom_range(0, eff_rpp - 1), $urandom_range(0, eff_spr - 1));
    end else if (pick < 85) begin
      dst_id = place_server($urandom_range(0, eff_pods), $urandom_range(0, eff_rpp - 1),
                            $urandom_range(0, eff_spr - 1));
    end else begin
      src_id = 12'($urandom_range(0, 4095));
      dst_id = 12'($urandom_range(0, 4095));
    end
    send_flow(src_id, dst_id);
  endtask

  // receiver: ready with a randomly changing duty, plus one long stall on request
  initial begin : hop_sink
    int   ready_pct;
    logic hold_taken;
    ready_pct  = 100;
    hold_taken = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 80;
          2:       ready_pct = 40;
          default: ready_pct = 15;
        endcase
      end
      m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // watchdog: any transaction on either side counts as progress
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : flow_source
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    long_hold_req = 1'b0;
    burst_left    = 0;
    eff_spr       = 4;
    eff_rpp       = 4;
    eff_pods      = 4;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed flows at reset sizes: 4 servers, 4 racks, 2 aggs, 4 pods, 4 cores
    send_flow(12'd0,    12'd0);      // same server
    send_flow(12'd4095, 12'd4095);   // same server at the top of the id space
    send_flow(12'd0,    12'd3);      // same rack
    send_flow(12'd3,    12'd0);
    send_flow(12'd1,    12'd6);      // same pod, agg pointer walks
    send_flow(12'd2,    12'd15);
    send_flow(12'd5,    12'd9);
    send_flow(12'd0,    12'd16);     // across pods, core pointer walks and wraps
    send_flow(12'd17,   12'd35);
    send_flow(12'd40,   12'd63);
    send_flow(12'd63,   12'd0);
    send_flow(12'd4095, 12'd0);      // source pod clamped to the last pod
    send_flow(12'd0,    12'd4095);
    send_flow(12'd48,   12'd4095);   // same pod only after clamping
    send_flow(12'd63,   12'd4095);   // same server only after clamping
    send_flow(12'd100,  12'd200);    // both clamped into the last pod
    send_flow(12'hAAA,  12'h555);
    send_flow(12'h555,  12'hAAA);
    send_flow(12'd20,   12'd24);

    for (int phase = 0; phase < PHASES; phase++) begin
      apply_sizes(phase_sizes(phase));
      if (phase == 5) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_FLOWS; k++) send_random_flow();
    end

    drain_flows();
    if (mismatches == 0 && hops_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ftps_pkg.sv
src/ftps_div.sv
src/ftps_ctrl.sv
src/ftps_dp.sv
src/fat_tree_path_selector.sv
verif/ftps_route_checker.sv
verif/fat_tree_path_selector_tb.sv
